// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pstc_pkg.sv
// ---------------------------------------------------------------------------
// pstc_pkg
// Types and constants of the power source transfer controller.
// ---------------------------------------------------------------------------
package pstc_pkg;

    // Timing of the periodic tasks, in 1 ms ticks.
    localparam logic [3:0] TICKS_PER_CHECK = 4'd10;
    localparam logic [6:0] TICKS_PER_STEP  = 7'd100;
    // Millisecond phase loaded when the line pin goes low.
    localparam logic [3:0] MS_PHASE_LINE_LOSS = 4'd6;

    // Event kinds carried in the request's tuser.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_GEN  = 2'd1;
    localparam logic [1:0] CMD_LINE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_TIME    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GEN_HOLD      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RETURN_DELAY  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTVL  = 3'd4;

    typedef enum logic [1:0] {
        POS_UNKNOWN = 2'd0,
        POS_LINE    = 2'd1,
        POS_GEN     = 2'd2
    } pos_t;

    typedef enum logic [1:0] {
        ACT_IDLE  = 2'd0,
        ACT_LINE  = 2'd1,
        ACT_GEN   = 2'd2,
        ACT_DELAY = 2'd3
    } act_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] relay_pulse_time;
        logic       gen_relay_hold;
        logic [7:0] line_return_delay;
        logic [7:0] line_repeat_count;
        logic [7:0] line_repeat_interval;
    } cfg_t;

    // Controller state, including relay and LED drives.
    typedef struct packed {
        logic [3:0] ms_phase;
        logic [6:0] tenth_phase;
        logic [7:0] seq_timer;
        logic       line_level;
        logic       line_seen;
        logic       gen_seen;
        logic [7:0] repeats_left;
        pos_t       pos;
        act_t       activity;
        logic       line_relay;
        logic       gen_relay;
        logic       line_led;
        logic       gen_led;
    } st_t;

endpackage

// File: sv/pstc_cfg_regs.sv
// ---------------------------------------------------------------------------
// pstc_cfg_regs
// Configuration register file with a plain write port.
// ---------------------------------------------------------------------------
module pstc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pstc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_wdata,
    output pstc_pkg::cfg_t                 cfg
);
    import pstc_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.relay_pulse_time     <= 8'd5;
            cfg_reg.gen_relay_hold       <= 1'b1;
            cfg_reg.line_return_delay    <= 8'd100;
            cfg_reg.line_repeat_count    <= 8'd3;
            cfg_reg.line_repeat_interval <= 8'd250;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PULSE_TIME:   cfg_reg.relay_pulse_time     <= cfg_wdata;
                REG_GEN_HOLD:     cfg_reg.gen_relay_hold       <= cfg_wdata[0];
                REG_RETURN_DELAY: cfg_reg.line_return_delay    <= cfg_wdata;
                REG_REPEAT_COUNT: cfg_reg.line_repeat_count    <= cfg_wdata;
                REG_REPEAT_INTVL: cfg_reg.line_repeat_interval <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/pstc_step.sv
// ---------------------------------------------------------------------------
// pstc_step
// Next-state logic for one event: tick phases, line check and sequencer.
// ---------------------------------------------------------------------------
module pstc_step (
    input  pstc_pkg::st_t  cur,
    input  pstc_pkg::cfg_t cfg,
    input  logic [1:0]     command,
    input  logic           pin_level,
    output pstc_pkg::st_t  nxt
);
    import pstc_pkg::*;

    // Start a generator relay pulse.
    function automatic st_t gen_pulse(input st_t s, input logic [7:0] len);
        st_t r;
        r = s;
        r.gen_led     = 1'b0;
        r.gen_relay   = 1'b1;
        r.activity    = ACT_GEN;
        r.seq_timer   = len;
        r.tenth_phase = '0;
        return r;
    endfunction

    // Start a line relay pulse.
    function automatic st_t line_pulse(input st_t s, input logic [7:0] len);
        st_t r;
        r = s;
        r.gen_relay   = 1'b0;
        r.line_led    = 1'b0;
        r.line_relay  = 1'b1;
        r.activity    = ACT_LINE;
        r.seq_timer   = len;
        r.tenth_phase = '0;
        return r;
    endfunction

    // Line check, run every check period.
    function automatic st_t line_check(input st_t s, input cfg_t c);
        st_t r;
        r = s;
        if (!r.line_level)
        begin
            r.line_led = 1'b0;
            case (r.activity)
                ACT_IDLE:
                begin
                    if (r.pos == POS_LINE && r.gen_seen)
                        r = gen_pulse(r, c.relay_pulse_time);
                end
                ACT_LINE:
                begin
                    r.line_relay = 1'b0;
                    if (r.gen_seen)
                        r = gen_pulse(r, c.relay_pulse_time);
                    else
                    begin
                        r.repeats_left = '0;
                        r.activity     = ACT_IDLE;
                        r.pos          = POS_UNKNOWN;
                    end
                end
                ACT_DELAY:
                begin
                    r.repeats_left = '0;
                    r.activity     = ACT_IDLE;
                end
                default: ;
            endcase
        end
        else if (r.line_seen != r.line_level)
            r.line_led = 1'b1;
        r.line_seen = r.line_level;
        return r;
    endfunction

    // Sequencer, run every step period.
    function automatic st_t seq_step(input st_t s, input cfg_t c);
        st_t r;
        r = s;
        if (r.activity == ACT_IDLE)
        begin
            r.gen_led = r.gen_seen && !r.gen_relay;
            if (r.pos == POS_GEN)
            begin
                if (r.line_seen)
                begin
                    if (!r.gen_seen)
                    begin
                        r.gen_led = 1'b0;
                        r = line_pulse(r, c.relay_pulse_time);
                    end
                    else
                    begin
                        r.line_led     = 1'b1;
                        r.repeats_left = c.line_repeat_count;
                        r.activity     = ACT_DELAY;
                        r.seq_timer    = c.line_return_delay;
                        r.tenth_phase  = '0;
                    end
                end
            end
            else if (r.pos == POS_UNKNOWN)
            begin
                if (r.line_seen)
                    r = line_pulse(r, c.relay_pulse_time);
                else if (r.gen_seen)
                begin
                    r.line_relay = 1'b0;
                    r = gen_pulse(r, c.relay_pulse_time);
                end
            end
        end
        else if (r.activity == ACT_DELAY)
            r.line_led = !r.line_led;

        // Timer countdown and expiry actions.
        if (r.seq_timer != '0)
        begin
            r.seq_timer = r.seq_timer - 8'd1;
            if (r.seq_timer == '0)
            begin
                case (r.activity)
                    ACT_LINE:
                    begin
                        r.line_relay = 1'b0;
                        r.line_led   = 1'b1;
                        if (r.repeats_left != '0)
                            r.seq_timer = c.line_repeat_interval;
                        r.activity = ACT_IDLE;
                        r.pos      = POS_LINE;
                    end
                    ACT_GEN:
                    begin
                        if (!c.gen_relay_hold)
                            r.gen_relay = 1'b0;
                        r.activity = ACT_IDLE;
                        r.pos      = POS_GEN;
                    end
                    ACT_DELAY:
                    begin
                        r.repeats_left = c.line_repeat_count;
                        r = line_pulse(r, c.relay_pulse_time);
                    end
                    default:
                    begin
                        if (r.repeats_left != '0)
                        begin
                            r.repeats_left = r.repeats_left - 8'd1;
                            if (r.pos == POS_LINE)
                                r = line_pulse(r, c.relay_pulse_time);
                        end
                    end
                endcase
            end
        end
        r.gen_seen = 1'b0;
        return r;
    endfunction

    // Event decode and update.
    always_comb
    begin
        nxt = cur;
        unique case (command)
            CMD_TICK:
            begin
                nxt.ms_phase = cur.ms_phase + 4'd1;
                if (nxt.ms_phase >= TICKS_PER_CHECK)
                begin
                    nxt.ms_phase = '0;
                    nxt = line_check(nxt, cfg);
                end
                nxt.tenth_phase = nxt.tenth_phase + 7'd1;
                if (nxt.tenth_phase >= TICKS_PER_STEP)
                begin
                    nxt.tenth_phase = '0;
                    nxt = seq_step(nxt, cfg);
                end
            end
            CMD_GEN:
            begin
                if (pin_level)
                    nxt.gen_seen = 1'b1;
            end
            CMD_LINE:
            begin
                nxt.line_level = pin_level;
                if (!pin_level)
                    nxt.ms_phase = MS_PHASE_LINE_LOSS;
            end
            default: ;
        endcase
    end

endmodule

// File: sv/power_source_transfer_controller_core.sv
// ---------------------------------------------------------------------------
// power_source_transfer_controller_core
// Automatic transfer switch controller between mains line and generator.
// Each request is one event (1 ms tick, generator pin change or line pin
// change) and yields one result with the relay and LED drives, the known
// position and the current activity after that event. The block takes one
// request per clock cycle while results are taken; a stalled result holds off
// new requests. A request is captured in the input register and its result is
// loaded into the result register once that slot is free. The rate is set by the
// single state update between the two registers, which reads the state left by
// the previous event. Configuration is to be written through the plain write port
// while no request is in flight; the block does not enforce this. Configuration
// registers reset to their defaults and the state and valid flags to zero.
// ---------------------------------------------------------------------------
module power_source_transfer_controller_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // Event requests.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] pin_level, rest zero
    input  logic [1:0]                       s_tuser,   // [1:0] command
    // Results.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [0] line_relay, [1] gen_relay,
                                                        // [2] line_led, [3] gen_led,
                                                        // [5:4] position, [7:6] activity
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [pstc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_wdata
);
    import pstc_pkg::*;

    cfg_t       cfg;
    st_t        st_reg;
    st_t        st_next;
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic       in_level_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       advance;
    logic       s_accept;

    pstc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pstc_step u_step (
        .cur       (st_reg),
        .cfg       (cfg),
        .command   (in_cmd_reg),
        .pin_level (in_level_reg),
        .nxt       (st_next)
    );

    // Pipeline handshake: the input stage moves on when the result slot frees.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg   <= s_tuser;
            in_level_reg <= s_tdata[0];
        end
    end

    // Controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
            st_reg <= st_next;
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {st_next.activity, st_next.pos, st_next.gen_led,
                             st_next.line_led, st_next.gen_relay, st_next.line_relay};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sv/pstc_checker.sv
// ---------------------------------------------------------------------------
// pstc_checker
// Port-level checks of the transfer controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pstc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [7:0]                       s_tdata,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [7:0]                       m_tdata,
    input logic                             cfg_we,
    input logic [pstc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [7:0]                       cfg_wdata
);
    import pstc_pkg::*;

    logic res_stall;
    logic res_line_busy;
    logic res_gen_busy;

    // Result-side conditions used below.
    assign res_stall     = m_tvalid && !m_tready;
    assign res_line_busy = m_tvalid && (m_tdata[7:6] == ACT_LINE);
    assign res_gen_busy  = m_tvalid && (m_tdata[7:6] == ACT_GEN);

    // A stalled result holds.
    `ASSERT_CLK(a_hold, res_stall |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // No result is offered right after reset.
    `ASSERT_ALWAYS(a_reset, !rst_n |=> !m_tvalid, "result offered after reset")

    // The position code never takes the unused value.
    `ASSERT_CLK(a_pos, m_tvalid |-> m_tdata[5:4] != 2'd3, "invalid position code")

    // A line pulse drives the line relay only; a generator pulse drives its relay.
    `ASSERT_CLK(a_line_pulse, res_line_busy |-> m_tdata[0] && !m_tdata[1], "line pulse drive wrong")
    `ASSERT_CLK(a_gen_pulse, res_gen_busy |-> m_tdata[1], "generator pulse without relay drive")

endmodule

bind power_source_transfer_controller_core pstc_checker u_pstc_checker (.*);

// File: tb/tb_power_source_transfer_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_source_transfer_controller_core
// Self-checking testbench for the line/generator transfer controller core.
// A directed opening covers every event kind and both pin levels. Random
// scenarios follow under several register settings, including zero timings and
// all maxima. In these scenarios the line comes and goes and the generator
// starts and stops, with tick runs between pin changes. A scoreboard class
// predicts the relay, LED, position and activity outputs after every event.
// Both handshake sides are throttled at random.
// ----------------------------------------------------------------------------
module tb_power_source_transfer_controller_core;

    import pstc_pkg::*;

    // Event kind that the controller ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Cycles with no accepted request or result before the run is abandoned.
    localparam int STALL_LIMIT = 1000;

    // One result word, packed as on m_tdata.
    typedef struct packed {
        act_t activity;
        pos_t position;
        logic gen_led;
        logic line_led;
        logic gen_relay;
        logic line_relay;
    } drive_word_t;

    // Predicts the controller outputs and checks the results against them.
    class switch_scoreboard;
        cfg_t        regs;
        st_t         ctl;
        drive_word_t pending_drives[$];
        int          failures;
        int          checked;
        int          ticks;
        int          other_events;
        int          seq_steps;
        int          pulses;

        function new();
            regs.relay_pulse_time     = 8'd5;
            regs.gen_relay_hold       = 1'b1;
            regs.line_return_delay    = 8'd100;
            regs.line_repeat_count    = 8'd3;
            regs.line_repeat_interval = 8'd250;
            ctl = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
            case (idx)
                REG_PULSE_TIME:   regs.relay_pulse_time     = value;
                REG_GEN_HOLD:     regs.gen_relay_hold       = value[0];
                REG_RETURN_DELAY: regs.line_return_delay    = value;
                REG_REPEAT_COUNT: regs.line_repeat_count    = value;
                REG_REPEAT_INTVL: regs.line_repeat_interval = value;
                default: ;
            endcase
        endfunction

        // Energize one relay and load the pulse timer.
        function void begin_pulse(act_t kind);
            if (kind == ACT_GEN)
            begin
                ctl.gen_led   = 1'b0;
                ctl.gen_relay = 1'b1;
            end
            else
            begin
                ctl.gen_relay  = 1'b0;
                ctl.line_led   = 1'b0;
                ctl.line_relay = 1'b1;
            end
            ctl.activity    = kind;
            ctl.seq_timer   = regs.relay_pulse_time;
            ctl.tenth_phase = '0;
            pulses++;
        endfunction

        // Apply one accepted event and queue the outputs it leaves behind.
        function void note_event(logic [1:0] cmd, logic level);
            drive_word_t word;
            if (cmd == CMD_TICK)
            begin
                ticks++;
                ctl.ms_phase = ctl.ms_phase + 4'd1;
                // Line check every TICKS_PER_CHECK ticks.
                if (ctl.ms_phase >= TICKS_PER_CHECK)
                begin
                    ctl.ms_phase = '0;
                    if (!ctl.line_level)
                    begin
                        ctl.line_led = 1'b0;
                        case (ctl.activity)
                            ACT_IDLE:
                            begin
                                if (ctl.pos == POS_LINE && ctl.gen_seen)
                                    begin_pulse(ACT_GEN);
                            end
                            ACT_LINE:
                            begin
                                ctl.line_relay = 1'b0;
                                if (ctl.gen_seen)
                                    begin_pulse(ACT_GEN);
                                else
                                begin
                                    ctl.repeats_left = '0;
                                    ctl.activity     = ACT_IDLE;
                                    ctl.pos          = POS_UNKNOWN;
                                end
                            end
                            ACT_DELAY:
                            begin
                                ctl.repeats_left = '0;
                                ctl.activity     = ACT_IDLE;
                            end
                            default: ;
                        endcase
                    end
                    else if (ctl.line_seen != ctl.line_level)
                        ctl.line_led = 1'b1;
                    ctl.line_seen = ctl.line_level;
                end
                // Sequencer every TICKS_PER_STEP ticks.
                ctl.tenth_phase = ctl.tenth_phase + 7'd1;
                if (ctl.tenth_phase >= TICKS_PER_STEP)
                begin
                    ctl.tenth_phase = '0;
                    seq_steps++;
                    if (ctl.activity == ACT_IDLE)
                    begin
                        ctl.gen_led = ctl.gen_seen && !ctl.gen_relay;
                        if (ctl.pos == POS_GEN)
                        begin
                            if (ctl.line_seen)
                            begin
                                if (!ctl.gen_seen)
                                begin
                                    ctl.gen_led = 1'b0;
                                    begin_pulse(ACT_LINE);
                                end
                                else
                                begin
                                    // Generator still running: hold off the return.
                                    ctl.line_led     = 1'b1;
                                    ctl.repeats_left = regs.line_repeat_count;
                                    ctl.activity     = ACT_DELAY;
                                    ctl.seq_timer    = regs.line_return_delay;
                                    ctl.tenth_phase  = '0;
                                end
                            end
                        end
                        else if (ctl.pos == POS_UNKNOWN)
                        begin
                            if (ctl.line_seen)
                                begin_pulse(ACT_LINE);
                            else if (ctl.gen_seen)
                            begin
                                ctl.line_relay = 1'b0;
                                begin_pulse(ACT_GEN);
                            end
                        end
                    end
                    else if (ctl.activity == ACT_DELAY)
                        ctl.line_led = !ctl.line_led;
                    // The timer only counts down from a nonzero value.
                    if (ctl.seq_timer != '0)
                    begin
                        ctl.seq_timer = ctl.seq_timer - 8'd1;
                        if (ctl.seq_timer == '0)
                        begin
                            case (ctl.activity)
                                ACT_LINE:
                                begin
                                    ctl.line_relay = 1'b0;
                                    ctl.line_led   = 1'b1;
                                    if (ctl.repeats_left != '0)
                                        ctl.seq_timer = regs.line_repeat_interval;
                                    ctl.activity = ACT_IDLE;
                                    ctl.pos      = POS_LINE;
                                end
                                ACT_GEN:
                                begin
                                    if (!regs.gen_relay_hold)
                                        ctl.gen_relay = 1'b0;
                                    ctl.activity = ACT_IDLE;
                                    ctl.pos      = POS_GEN;
                                end
                                ACT_DELAY:
                                begin
                                    ctl.repeats_left = regs.line_repeat_count;
                                    begin_pulse(ACT_LINE);
                                end
                                default:
                                begin
                                    // Repeated line pulse while idle.
                                    if (ctl.repeats_left != '0)
                                    begin
                                        ctl.repeats_left = ctl.repeats_left - 8'd1;
                                        if (ctl.pos == POS_LINE)
                                            begin_pulse(ACT_LINE);
                                    end
                                end
                            endcase
                        end
                    end
                    ctl.gen_seen = 1'b0;
                end
            end
            else
            begin
                other_events++;
                if (cmd == CMD_GEN)
                begin
                    if (level)
                        ctl.gen_seen = 1'b1;
                end
                else if (cmd == CMD_LINE)
                begin
                    ctl.line_level = level;
                    if (!level)
                        ctl.ms_phase = MS_PHASE_LINE_LOSS;
                end
            end
            word.line_relay = ctl.line_relay;
            word.gen_relay  = ctl.gen_relay;
            word.line_led   = ctl.line_led;
            word.gen_led    = ctl.gen_led;
            word.position   = ctl.pos;
            word.activity   = ctl.activity;
            pending_drives.push_back(word);
        endfunction

        function void compare(string what, logic [1:0] want, logic [1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", what, want, got);
                failures++;
            end
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_drive(logic [7:0] data);
            drive_word_t got;
            drive_word_t want;
            got = drive_word_t'(data);
            if (pending_drives.size() == 0)
            begin
                $error("result %h arrived with no event outstanding", data);
                failures++;
                return;
            end
            want = pending_drives.pop_front();
            checked++;
            compare("line_relay", want.line_relay, got.line_relay);
            compare("gen_relay", want.gen_relay, got.gen_relay);
            compare("line_led", want.line_led, got.line_led);
            compare("gen_led", want.gen_led, got.gen_led);
            compare("position", want.position, got.position);
            compare("activity", want.activity, got.activity);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // [0] pin_level, rest zero
    logic [1:0]             s_tuser;    // [1:0] command
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;    // [0] line_relay, [1] gen_relay, [2] line_led,
                                        // [3] gen_led, [5:4] position, [7:6] activity
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_wdata;

    switch_scoreboard sb;
    bit               quiet;
    int               stall_cycles;

    power_source_transfer_controller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Score every accepted request and result at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_drive(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_event(s_tuser, s_tdata[0]);
        end
    end

    // Abort when neither side makes progress for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_power_source_transfer_controller_core NOT OK");
                $finish;
            end
        end
    end

    // Result side: a random stall before each result, none in quiet stretches.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Offer one event after a random gap and hold it until it is taken.
    task automatic send_event(input logic [1:0] cmd, input logic level);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, level};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Ticks carry a random, ignored pin level.
    task automatic tick_run(input int count);
        repeat (count) send_event(CMD_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_drives.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] pulse, input logic hold,
                                 input logic [7:0] delay, input logic [7:0] repeats,
                                 input logic [7:0] spacing);
        write_reg(REG_PULSE_TIME, pulse);
        write_reg(REG_GEN_HOLD, {7'd0, hold});
        write_reg(REG_RETURN_DELAY, delay);
        write_reg(REG_REPEAT_COUNT, repeats);
        write_reg(REG_REPEAT_INTVL, spacing);
        cfg_we <= 1'b0;
    endtask

    // Line outages and generator runs with tick runs between pin changes;
    // a few events are bounces, stray generator highs or unused commands.
    task automatic run_scenario(input int n_events);
        bit line_up;
        bit gen_on;
        bit gen_pin;
        int pick;
        line_up = 1'($urandom_range(0, 1));
        gen_on  = 1'b0;
        gen_pin = 1'b0;
        repeat (n_events)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            tick_run($urandom_range(1, 40));
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if (gen_on)
                    gen_pin = !gen_pin;
                else
                    gen_pin = ($urandom_range(0, 9) == 0);
                send_event(CMD_GEN, gen_pin);
            end
            else if (pick < 56)
            begin
                if ($urandom_range(0, 3) == 0)
                    line_up = !line_up;
                send_event(CMD_LINE, line_up);
            end
            else if (pick < 61)
                send_event(CMD_UNUSED, 1'($urandom_range(0, 1)));
            else if (pick < 68)
                gen_on = !gen_on;
        end
        drain_results();
    endtask

    // Main sequence.
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_TICK;
        cfg_we       = 1'b0;
        cfg_index    = REG_PULSE_TIME;
        cfg_wdata    = '0;
        quiet        = 1'b0;
        stall_cycles = 0;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every event kind at both levels, line rise and line loss.
        tick_run(2);
        send_event(CMD_GEN, 1'b0);
        send_event(CMD_GEN, 1'b1);
        send_event(CMD_UNUSED, 1'b0);
        send_event(CMD_UNUSED, 1'b1);
        send_event(CMD_LINE, 1'b1);
        tick_run(10);
        send_event(CMD_LINE, 1'b0);
        tick_run(4);
        drain_results();

        // Random scenarios under reset defaults, then under written settings.
        run_scenario(3);
        load_settings(8'd1, 1'b0, 8'd2, 8'd2, 8'd1);
        run_scenario(3);
        load_settings(8'd0, 1'b1, 8'd0, 8'd0, 8'd0);
        run_scenario(3);
        load_settings(8'd255, 1'b1, 8'd255, 8'd255, 8'd255);
        run_scenario(3);
        load_settings(8'd2, 1'b1, 8'd1, 8'd255, 8'd1);
        run_scenario(3);
        load_settings(8'($urandom_range(1, 4)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 4)), 8'($urandom_range(0, 5)),
                      8'($urandom_range(0, 4)));
        run_scenario(3);
        load_settings(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        run_scenario(3);

        $display("Checked %0d results: %0d ticks and %0d pin or unused events, 7 settings.",
                 sb.checked, sb.ticks, sb.other_events);
        $display("The sequencer ran %0d steps and started %0d relay pulses.",
                 sb.seq_steps, sb.pulses);
        if (sb.failures == 0)
            $display("tb_power_source_transfer_controller_core OK");
        else
            $display("tb_power_source_transfer_controller_core NOT OK");
        $finish;
    end

endmodule
